/* design/assert_macros.svh */
// Assertion macros shared by the priority queue RTL.
// Needs a clock named clk and a synchronous reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define SPQ_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* design/spq_pkg.sv */
// Types, codes and constants of the three-level stable priority queue.
// No dependencies.
`timescale 1ns / 1ps
package spq_pkg;

  localparam int CAPACITY_DEF    = 64;
  localparam int NUM_CLASSES_DEF = 3;
  localparam int CFG_W           = 7;
  localparam int CLS_W           = 3;   // enough for up to eight classes
  localparam logic [CFG_W-1:0] CAP_LIMIT_RST = 7'd64;

  typedef enum logic [1:0] {
    ACT_ENQ   = 2'd0,
    ACT_DEQ   = 2'd1,
    ACT_PEEK  = 2'd2,
    ACT_CLEAR = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2,
    ST_EMPTY   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    OP_HOLD  = 2'd0,
    OP_PUSH  = 2'd1,
    OP_POP   = 2'd2,
    OP_CLEAR = 2'd3
  } cell_op_t;

  typedef struct packed {
    act_t               action;
    logic signed [31:0] package_id;
    logic signed [7:0]  priority_req;
    logic signed [31:0] weight;
    logic [15:0]        payload_handle;
    logic               text_ok;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic [30:0] out_id;
    logic [1:0]  out_priority;
    logic [30:0] out_weight;
    logic [15:0] out_payload;
    logic [6:0]  count;
    logic        is_empty;
  } rsp_t;

  typedef struct packed {
    logic             vld;
    logic [CLS_W-1:0] cls;
    logic [30:0]      id;
    logic [30:0]      wt;
    logic [15:0]      pay;
  } entry_t;

  typedef struct packed {
    cell_op_t op;
    entry_t   ent;
  } ctl_t;

  // Fed to the left of the first cell: valid and of the lowest class.
  localparam entry_t HEAD_SENTINEL = '{vld: 1'b1, cls: '0, id: '0, wt: '0, pay: '0};
  localparam entry_t EMPTY_ENTRY   = '{vld: 1'b0, cls: '0, id: '0, wt: '0, pay: '0};

endpackage

/* design/spq_cell.sv */
// One cell of the sorted queue chain: holds one record, shifts right on
// insert, left on pop. Depends on spq_pkg.
`timescale 1ns / 1ps
module spq_cell (
  input  logic            clk,
  input  logic            rst,
  input  spq_pkg::ctl_t   ctl,
  input  spq_pkg::entry_t left,
  input  spq_pkg::entry_t right,
  output spq_pkg::entry_t ent
);
  import spq_pkg::*;

  entry_t ent_next;
  logic   left_after;
  logic   left_before;
  logic   here_after;

  assign left_after  = left.vld && (left.cls > ctl.ent.cls);
  assign left_before = left.vld && (left.cls <= ctl.ent.cls);
  assign here_after  = !ent.vld || (ent.cls > ctl.ent.cls);

  always_comb begin
    ent_next = ent;
    case (ctl.op)
      OP_PUSH: begin
        if (left_after) begin
          ent_next = left;
        end else if (here_after && left_before) begin
          ent_next = ctl.ent;
        end
      end
      OP_POP:   ent_next = right;
      OP_CLEAR: ent_next.vld = 1'b0;
      default:  ent_next = ent;
    endcase
  end

  always_ff @(posedge clk) begin
    ent.cls <= ent_next.cls;
    ent.id  <= ent_next.id;
    ent.wt  <= ent_next.wt;
    ent.pay <= ent_next.pay;
    if (rst) begin
      ent.vld <= 1'b0;
    end else begin
      ent.vld <= ent_next.vld;
    end
  end

endmodule

/* design/spq_outbuf.sv */
// Two-entry response buffer between the queue and the response channel.
// Depends on spq_pkg.
`timescale 1ns / 1ps
module spq_outbuf (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  spq_pkg::rsp_t item,
  output logic          full,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output spq_pkg::rsp_t rsp
);
  import spq_pkg::*;

  logic [1:0] lvl;
  logic [1:0] lvl_next;
  rsp_t       spare;
  logic       pop;

  assign pop       = rsp_valid && !rsp_stall;
  assign full      = (lvl == 2'd2);
  assign rsp_valid = (lvl != 2'd0);

  always_comb begin
    lvl_next = lvl;
    if (push && !pop) begin
      lvl_next = lvl + 2'd1;
    end else if (pop && !push) begin
      lvl_next = lvl - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lvl <= 2'd0;
    end else begin
      lvl <= lvl_next;
    end
  end

  always_ff @(posedge clk) begin
    if (lvl == 2'd2) begin
      if (pop) begin
        rsp   <= spare;
        spare <= item;
      end
    end else if (lvl == 2'd1) begin
      if (pop && push) begin
        rsp <= item;
      end else if (push) begin
        spare <= item;
      end
    end else if (push) begin
      rsp <= item;
    end
  end

endmodule

/* design/three_level_stable_priority_queue.sv */
// Stable priority queue: a chain of cells kept sorted by class, FIFO within a class.
// Each accepted request's response is registered in the response buffer.
// Throughput: one request per cycle; a two-entry response buffer stalls requests
// only when full. Every request touches all cells at once through the chain.
// Reset (synchronous): queue empty, capacity limit 64; record storage is not cleared.
// Depends on spq_pkg, spq_cell, spq_outbuf and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module three_level_stable_priority_queue #(
  parameter int CAPACITY    = spq_pkg::CAPACITY_DEF,
  parameter int NUM_CLASSES = spq_pkg::NUM_CLASSES_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [spq_pkg::CFG_W-1:0] cfg_wdata,
  input  logic                      req_valid,
  output logic                      req_stall,
  input  spq_pkg::req_t             req,
  output logic                      rsp_valid,
  input  logic                      rsp_stall,
  output spq_pkg::rsp_t             rsp
);
  import spq_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int LW    = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  logic [CFG_W-1:0] cap_limit;
  logic [CNT_W-1:0] total;
  logic [CNT_W-1:0] total_next;
  entry_t           cells [CAPACITY];
  ctl_t             ctl;
  rsp_t             item;
  logic             req_acc;
  logic             rec_ok;
  logic             full;
  entry_t           head;

  assign req_acc = req_valid && !req_stall;
  assign head    = cells[0];

  assign rec_ok = !req.package_id[31] && (req.package_id[30:0] != '0) &&
                  !req.priority_req[7] &&
                  (req.priority_req[6:0] < 7'(NUM_CLASSES)) &&
                  !req.weight[31] && req.text_ok;

  assign full = (LW'(total) >= LW'(CAPACITY)) || (LW'(total) >= LW'(cap_limit));

  always_comb begin
    ctl.op      = OP_HOLD;
    ctl.ent.vld = 1'b1;
    ctl.ent.cls = CLS_W'(req.priority_req[6:0]);
    ctl.ent.id  = req.package_id[30:0];
    ctl.ent.wt  = req.weight[30:0];
    ctl.ent.pay = req.payload_handle;
    total_next  = total;
    item        = '0;
    item.status = ST_OK;
    case (req.action)
      ACT_ENQ: begin
        if (!rec_ok) begin
          item.status = ST_INVALID;
        end else if (full) begin
          item.status = ST_FULL;
        end else begin
          ctl.op     = OP_PUSH;
          total_next = total + CNT_W'(1);
        end
      end
      ACT_DEQ, ACT_PEEK: begin
        if (!head.vld) begin
          item.status = ST_EMPTY;
        end else begin
          item.out_id       = head.id;
          item.out_priority = 2'(head.cls);
          item.out_weight   = head.wt;
          item.out_payload  = head.pay;
          if (req.action == ACT_DEQ) begin
            ctl.op     = OP_POP;
            total_next = total - CNT_W'(1);
          end
        end
      end
      ACT_CLEAR: begin
        ctl.op     = OP_CLEAR;
        total_next = '0;
      end
      default: item.status = ST_OK;
    endcase
    if (!req_acc) begin
      ctl.op     = OP_HOLD;
      total_next = total;
    end
    item.count    = 7'(total_next);
    item.is_empty = (total_next == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_limit <= CAP_LIMIT_RST;
      total     <= '0;
    end else begin
      if (cfg_we) begin
        cap_limit <= cfg_wdata;
      end
      total <= total_next;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t left;
    entry_t right;
    if (i == 0) begin : g_first
      assign left = HEAD_SENTINEL;
    end else begin : g_mid
      assign left = cells[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right = EMPTY_ENTRY;
    end else begin : g_inner
      assign right = cells[i+1];
    end
    spq_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .ctl   (ctl),
      .left  (left),
      .right (right),
      .ent   (cells[i])
    );
  end

  spq_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .push      (req_acc),
    .item      (item),
    .full      (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  `SPQ_ASSERT_ALWAYS(a_head_matches_count, (total == '0) == !cells[0].vld, "head cell and count disagree")
  `SPQ_ASSERT_ALWAYS(a_count_bounded, LW'(total) <= LW'(CAPACITY), "record count above capacity")
  `SPQ_ASSERT_NEXT(a_push_counts, ctl.op == OP_PUSH, total == $past(total) + CNT_W'(1), "push did not count")
  `SPQ_ASSERT_NEXT(a_clear_empties, ctl.op == OP_CLEAR, (total == '0) && !cells[0].vld, "clear left records")

endmodule
